// File: design/stlm_pkg.sv
// ----------------------------------------------------------------------------
// stlm_pkg
// Shared types and codes of the sorted timer list manager.
// ----------------------------------------------------------------------------
package stlm_pkg;

	localparam int TIMER_SLOTS_DEF = 32;
	localparam int SLOT_W          = 5;
	localparam int DL_W            = 32;
	localparam int OWNER_W         = 8;
	localparam int DATA_W          = 32;

	localparam logic [2:0] MODE_TICK       = 3'd0;
	localparam logic [2:0] MODE_ALLOC      = 3'd1;
	localparam logic [2:0] MODE_FREE       = 3'd2;
	localparam logic [2:0] MODE_INIT       = 3'd3;
	localparam logic [2:0] MODE_ARM        = 3'd4;
	localparam logic [2:0] MODE_CANCEL     = 3'd5;
	localparam logic [2:0] MODE_CANCEL_ALL = 3'd6;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_EXPIRY = 2'd2;
	localparam logic [1:0] KIND_TASK   = 2'd3;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_POP
	} chain_op_t;

	typedef struct packed {
		logic              v;
		logic [SLOT_W-1:0] slot;
		logic [DL_W-1:0]   dl;
	} entry_t;

	typedef struct packed {
		chain_op_t         op;
		logic [SLOT_W-1:0] slot;
		logic [DL_W-1:0]   dl;
	} chain_cmd_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [SLOT_W-1:0]  slot;
		logic [OWNER_W-1:0] owner;
		logic [DATA_W-1:0]  payload;
		logic [DL_W-1:0]    delay;
		logic               auto_cancel;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               ok;
		logic [SLOT_W-1:0]  result_slot;
		logic [OWNER_W-1:0] dest_owner;
		logic [DATA_W-1:0]  result_data;
		logic               last;
	} rsp_item_t;

endpackage

// File: design/stlm_ram.sv
// ----------------------------------------------------------------------------
// stlm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module stlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/stlm_cell.sv
// ----------------------------------------------------------------------------
// stlm_cell
// One place of the sorted deadline list; shifts with its neighbors.
// ----------------------------------------------------------------------------
module stlm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stlm_pkg::chain_cmd_t cmd,
	input  stlm_pkg::entry_t    left,
	input  stlm_pkg::entry_t    right,
	input  logic                left_ge,
	input  logic                left_rm,
	output stlm_pkg::entry_t    ent,
	output logic                ge,
	output logic                rm
);

	stlm_pkg::entry_t entry_q;

	assign ent = entry_q;
	assign ge  = !entry_q.v || (cmd.dl <= entry_q.dl);
	assign rm  = left_rm || (entry_q.v && (entry_q.slot == cmd.slot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.v <= 1'b0;
		end else begin
			case (cmd.op)
				stlm_pkg::OP_INSERT: begin
					if (ge) begin
						if (left_ge) begin
							entry_q <= left;
						end else begin
							entry_q.v    <= 1'b1;
							entry_q.slot <= cmd.slot;
							entry_q.dl   <= cmd.dl;
						end
					end
				end
				stlm_pkg::OP_REMOVE: begin
					if (rm) begin
						entry_q <= right;
					end
				end
				stlm_pkg::OP_POP: begin
					entry_q <= right;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/sorted_timer_list_manager_core.sv
// ----------------------------------------------------------------------------
// sorted_timer_list_manager_core
// Pool of one-shot timers; running ones held sorted in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | signals                        | moves
//  req     | req_valid, req_ready, req      | one request (tick or API call)
//  rsp     | rsp_valid, rsp_ready, rsp      | replies, expiries, task switch
//  cfg     | cfg_valid, cfg_ready, cfg_data | task timer slot, always ready
//
//  Free and init finish in S_IDLE; alloc and cancel pass through S_REPLY; arm through S_ARM.
//  A tick runs S_TCHK, plus S_TREAD per expiry delivery and S_TSW for a task switch.
//  Cancel all walks slots 1 to USABLE-1 through the owner RAM, S_CARD then S_CACHK per slot.
//  Reset clears the list and slot states at once; no clearing pass.
//  A stalled rsp holds a tick's expiry walk; a new request waits for any walk to end.
// ----------------------------------------------------------------------------
module sorted_timer_list_manager_core #(
	parameter int TIMER_SLOTS = stlm_pkg::TIMER_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  stlm_pkg::req_item_t           req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output stlm_pkg::rsp_item_t           rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stlm_pkg::SLOT_W-1:0]   cfg_data
);

	localparam int USABLE = (TIMER_SLOTS < 32) ? TIMER_SLOTS : 32;
	localparam int CELLS  = USABLE - 1;
	localparam int IW     = $clog2(USABLE);
	localparam int RW     = stlm_pkg::OWNER_W + stlm_pkg::DATA_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_TCHK  = 9'b000000010,
		S_TREAD = 9'b000000100,
		S_TSW   = 9'b000001000,
		S_REPLY = 9'b000010000,
		S_ARM   = 9'b000100000,
		S_CARD  = 9'b001000000,
		S_CACHK = 9'b010000000,
		S_SPARE = 9'b100000000
	} state_t;

	state_t                              state_q;
	logic [1:0]                          status_q [USABLE];
	logic                                tagged_q [USABLE];
	logic [stlm_pkg::DL_W-1:0]           tick_q;
	logic [stlm_pkg::SLOT_W-1:0]         task_q;
	logic                                sw_q;
	logic [stlm_pkg::SLOT_W-1:0]         exp_slot_q;
	logic [stlm_pkg::SLOT_W-1:0]         arm_slot_q;
	logic [stlm_pkg::DL_W-1:0]           dl_q;
	logic [IW-1:0]                       ca_idx_q;
	logic [stlm_pkg::OWNER_W-1:0]        own_q;
	stlm_pkg::rsp_item_t                 pend_q;
	stlm_pkg::rsp_item_t                 rsp_q;
	logic                                rsp_valid_q;

	stlm_pkg::chain_cmd_t                cmd;
	stlm_pkg::entry_t                    ents [CELLS];
	logic                                ges [CELLS];
	logic                                rms [CELLS];
	stlm_pkg::entry_t                    head;
	logic                                due;
	logic                                accept;
	logic [IW-1:0]                       rq_idx;
	logic                                rq_ok;
	logic [1:0]                          rq_status;
	logic                                alloc_found;
	logic [IW-1:0]                       alloc_idx;
	logic [IW-1:0]                       raddr;
	logic [RW-1:0]                       rdata;
	logic                                ca_hit;
	logic                                emit_req;
	logic                                emit_go;
	stlm_pkg::rsp_item_t                 rsp_d;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rq_idx    = req.slot[IW-1:0];
	assign rq_ok     = (req.slot != '0) && (32'(req.slot) < USABLE);
	assign rq_status = status_q[rq_idx];

	assign head = ents[0];
	assign due  = head.v && (head.dl <= tick_q);

	always_comb begin
		alloc_found = 1'b0;
		alloc_idx   = '0;
		for (int i = USABLE - 1; i >= 1; i--) begin
			if (status_q[i] == stlm_pkg::ST_FREE) begin
				alloc_found = 1'b1;
				alloc_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		if (state_q == S_TCHK) begin
			raddr = head.slot[IW-1:0];
		end else if (state_q == S_TREAD) begin
			raddr = exp_slot_q[IW-1:0];
		end else begin
			raddr = ca_idx_q;
		end
	end

	stlm_ram #(
		.WIDTH(RW),
		.DEPTH(USABLE)
	) u_info_ram (
		.clk  (clk),
		.we   (accept && (req.mode == stlm_pkg::MODE_INIT) && rq_ok),
		.waddr(rq_idx),
		.wdata({req.owner, req.payload}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign ca_hit = (status_q[ca_idx_q] != stlm_pkg::ST_FREE) && tagged_q[ca_idx_q]
		&& (rdata[RW-1:stlm_pkg::DATA_W] == own_q);

	always_comb begin
		cmd.op   = stlm_pkg::OP_NONE;
		cmd.slot = req.slot;
		cmd.dl   = dl_q;
		if (accept && rq_ok) begin
			if (((req.mode == stlm_pkg::MODE_FREE) && (rq_status == stlm_pkg::ST_RUN))
				|| ((req.mode == stlm_pkg::MODE_ARM) && (rq_status != stlm_pkg::ST_FREE))
				|| ((req.mode == stlm_pkg::MODE_CANCEL) && (rq_status == stlm_pkg::ST_RUN))) begin
				cmd.op = stlm_pkg::OP_REMOVE;
			end
		end else if ((state_q == S_TCHK) && due) begin
			cmd.op = stlm_pkg::OP_POP;
		end else if (state_q == S_ARM) begin
			cmd.op   = stlm_pkg::OP_INSERT;
			cmd.slot = arm_slot_q;
		end else if ((state_q == S_CACHK) && ca_hit) begin
			cmd.op   = stlm_pkg::OP_REMOVE;
			cmd.slot = stlm_pkg::SLOT_W'(ca_idx_q);
		end
	end

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		stlm_pkg::entry_t lft;
		stlm_pkg::entry_t rgt;
		logic             lge;
		logic             lrm;
		if (g == 0) begin : g_first
			assign lft = '0;
			assign lge = 1'b0;
			assign lrm = 1'b0;
		end else begin : g_mid
			assign lft = ents[g-1];
			assign lge = ges[g-1];
			assign lrm = rms[g-1];
		end
		if (g == CELLS - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = ents[g+1];
		end
		stlm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (lft),
			.right  (rgt),
			.left_ge(lge),
			.left_rm(lrm),
			.ent    (ents[g]),
			.ge     (ges[g]),
			.rm     (rms[g])
		);
	end

	always_comb begin
		rsp_d    = '0;
		emit_req = 1'b0;
		if (state_q == S_TREAD) begin
			emit_req          = 1'b1;
			rsp_d.kind        = stlm_pkg::KIND_EXPIRY;
			rsp_d.result_slot = exp_slot_q;
			rsp_d.dest_owner  = rdata[RW-1:stlm_pkg::DATA_W];
			rsp_d.result_data = rdata[stlm_pkg::DATA_W-1:0];
			rsp_d.last        = !due && !sw_q;
		end else if (state_q == S_TSW) begin
			emit_req          = 1'b1;
			rsp_d.kind        = stlm_pkg::KIND_TASK;
			rsp_d.result_slot = task_q;
			rsp_d.last        = 1'b1;
		end else if (state_q == S_REPLY) begin
			emit_req = 1'b1;
			rsp_d    = pend_q;
		end
	end

	assign emit_go = emit_req && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= '0;
			task_q      <= '0;
			sw_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			ca_idx_q    <= IW'(1);
			for (int i = 0; i < USABLE; i++) begin
				status_q[i] <= (i == 0) ? stlm_pkg::ST_RUN : stlm_pkg::ST_FREE;
				tagged_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_valid) begin
				task_q <= cfg_data;
			end
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_q             <= '0;
						pend_q.result_slot <= req.slot;
						pend_q.last        <= 1'b1;
						unique case (req.mode)
							stlm_pkg::MODE_TICK: begin
								tick_q  <= tick_q + 1'b1;
								sw_q    <= 1'b0;
								state_q <= S_TCHK;
							end
							stlm_pkg::MODE_ALLOC: begin
								pend_q.kind        <= stlm_pkg::KIND_ALLOC;
								pend_q.ok          <= alloc_found;
								pend_q.result_slot <= stlm_pkg::SLOT_W'(alloc_idx);
								if (alloc_found) begin
									status_q[alloc_idx] <= stlm_pkg::ST_ALLOC;
									tagged_q[alloc_idx] <= 1'b0;
								end
								state_q <= S_REPLY;
							end
							stlm_pkg::MODE_FREE: begin
								if (rq_ok) begin
									status_q[rq_idx] <= stlm_pkg::ST_FREE;
								end
							end
							stlm_pkg::MODE_INIT: begin
								if (rq_ok) begin
									tagged_q[rq_idx] <= req.auto_cancel;
								end
							end
							stlm_pkg::MODE_ARM: begin
								if (rq_ok && (rq_status != stlm_pkg::ST_FREE)) begin
									status_q[rq_idx] <= stlm_pkg::ST_RUN;
									arm_slot_q       <= req.slot;
									dl_q             <= req.delay + tick_q;
									state_q          <= S_ARM;
								end
							end
							stlm_pkg::MODE_CANCEL: begin
								pend_q.kind <= stlm_pkg::KIND_CANCEL;
								if (rq_ok && (rq_status == stlm_pkg::ST_RUN)) begin
									status_q[rq_idx] <= stlm_pkg::ST_ALLOC;
									pend_q.ok        <= 1'b1;
								end
								state_q <= S_REPLY;
							end
							stlm_pkg::MODE_CANCEL_ALL: begin
								own_q    <= req.owner;
								ca_idx_q <= IW'(1);
								state_q  <= S_CARD;
							end
							default: begin
							end
						endcase
					end
				end
				S_TCHK: begin
					if (due) begin
						status_q[head.slot[IW-1:0]] <= stlm_pkg::ST_ALLOC;
						if (head.slot == task_q) begin
							sw_q <= 1'b1;
						end else begin
							exp_slot_q <= head.slot;
							state_q    <= S_TREAD;
						end
					end else if (sw_q) begin
						state_q <= S_TSW;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_TREAD: begin
					if (emit_go) begin
						state_q <= S_TCHK;
					end
				end
				S_TSW, S_REPLY: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				S_ARM: begin
					state_q <= S_IDLE;
				end
				S_CARD: begin
					state_q <= S_CACHK;
				end
				S_CACHK: begin
					if (ca_hit) begin
						status_q[ca_idx_q] <= stlm_pkg::ST_FREE;
					end
					if (32'(ca_idx_q) == USABLE - 1) begin
						state_q <= S_IDLE;
					end else begin
						ca_idx_q <= ca_idx_q + 1'b1;
						state_q  <= S_CARD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/stlm_checker.sv
// ----------------------------------------------------------------------------
// stlm_checker
// Port-level checks of the sorted timer list manager.
// ----------------------------------------------------------------------------
module stlm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input stlm_pkg::rsp_item_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.kind == stlm_pkg::KIND_ALLOC) || (rsp.kind == stlm_pkg::KIND_CANCEL)
		|| (rsp.kind == stlm_pkg::KIND_TASK)) |-> rsp.last)
		else $error("single response not marked last");

	a_expiry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.kind == stlm_pkg::KIND_EXPIRY) || (rsp.kind == stlm_pkg::KIND_TASK))
		|-> !rsp.ok)
		else $error("expiry response with ok set");

	a_alloc_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == stlm_pkg::KIND_ALLOC) && !rsp.ok |-> rsp.result_slot == '0)
		else $error("failed alloc names a slot");

	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |-> !req_ready)
		else $error("request taken before last response");

endmodule

bind sorted_timer_list_manager_core stlm_checker u_stlm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
